// ===== hdl/mrkc_pkg.sv =====
// Package for the multirate Runge-Kutta stage combiner: sizes, weight tables, helpers.
`default_nettype none

package mrkc_pkg;

    localparam int NUM_STAGES = 10;
    localparam int NUM_POINTS = 1024;
    localparam int NUM_VARS   = 4;

    localparam int STAGE_W   = 4;
    localparam int FINAL_STG = NUM_STAGES - 1;
    localparam int VAR_IN_W  = 2;
    localparam int PT_IN_W   = 10;
    localparam int DATA_W    = 32;

    localparam int VAR_W     = (NUM_VARS > 1) ? $clog2(NUM_VARS) : 1;
    localparam int PT_W      = (NUM_POINTS > 1) ? $clog2(NUM_POINTS) : 1;
    localparam int NUM_ROWS  = 2 * NUM_VARS * NUM_STAGES;
    localparam int ROW_W     = $clog2(NUM_ROWS);
    localparam int MEM_DEPTH = NUM_ROWS * NUM_POINTS;
    localparam int ADDR_W    = $clog2(MEM_DEPTH);

    // Accumulator holds 12*(old + 2^31) + 6 plus the weighted increments.
    localparam int ACC_W     = 42;
    localparam int WPROD_W   = 37;

    // Divide-by-three unit: seven quotient bits per cycle.
    localparam int DIV_BITS  = 7;
    localparam int DIV_STEPS = 5;
    localparam int Z_W       = DIV_BITS * DIV_STEPS;
    localparam int CNT_W     = $clog2(DIV_STEPS);

    localparam logic [1:0] REG_STAGE = 2'd0;
    localparam logic [1:0] REG_STEP  = 2'd1;

    typedef logic signed [4:0] t_weight;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_LOAD,
        ST_WRITE,
        ST_READ,
        ST_DRAIN,
        ST_CLAMP,
        ST_DIV,
        ST_OUT
    } t_state;

    localparam t_weight FAST_W [NUM_STAGES][NUM_STAGES] = '{
        '{ 3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-1, 4, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ 2,-2, 6, 0, 0, 0, 0, 0, 0, 0},
        '{ 1, 2, 2, 1, 0, 0, 0, 0, 0, 0},
        '{ 1, 2, 2, 2, 1, 0, 0, 0, 0, 0},
        '{ 1, 2, 2, 1, 0, 3, 0, 0, 0, 0},
        '{ 1, 2, 2, 1, 0,-1, 4, 0, 0, 0},
        '{ 1, 2, 2, 1, 0, 2,-2, 6, 0, 0},
        '{ 1, 2, 2, 1, 0, 1, 2, 2, 1, 0},
        '{ 1, 2, 2, 1, 0, 1, 2, 2, 1, 0}
    };

    localparam t_weight SLOW_W [NUM_STAGES][NUM_STAGES] = '{
        '{ 3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ 3, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ 6, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{ 6, 0, 0, 0, 0, 0, 0, 0, 0, 0},
        '{-2, 0, 0, 0, 8, 0, 0, 0, 0, 0},
        '{ 1, 0, 0, 0, 2, 6, 0, 0, 0, 0},
        '{ 1, 0, 0, 0, 2, 6, 0, 0, 0, 0},
        '{ 4, 0, 0, 0,-4,12, 0, 0, 0, 0},
        '{ 4, 0, 0, 0,-4,12, 0, 0, 0, 0},
        '{ 2, 0, 0, 0, 4, 4, 0, 0, 0, 2}
    };

    function automatic t_weight weight(input logic slow, input logic [STAGE_W-1:0] s,
                                       input logic [STAGE_W-1:0] k);
        t_weight w;
        w = slow ? SLOW_W[s][k] : FAST_W[s][k];
        return w;
    endfunction

    // Remainder by constant with restoring compare-and-subtract steps.
    function automatic logic [VAR_W-1:0] mod_vars(input logic [VAR_IN_W-1:0] v);
        logic [31:0] r;
        r = 32'(v);
        for (int i = VAR_IN_W - 1; i >= 0; i--) begin
            if (r >= 32'(NUM_VARS << i)) begin
                r = r - 32'(NUM_VARS << i);
            end
        end
        return VAR_W'(r);
    endfunction

    function automatic logic [PT_W-1:0] mod_points(input logic [PT_IN_W-1:0] p);
        logic [31:0] r;
        r = 32'(p);
        for (int i = PT_IN_W - 1; i >= 0; i--) begin
            if (r >= 32'(NUM_POINTS << i)) begin
                r = r - 32'(NUM_POINTS << i);
            end
        end
        return PT_W'(r);
    endfunction

endpackage

`default_nettype wire

// ===== hdl/multirate_rk_stage_combine.sv =====
// Top level of the multirate Runge-Kutta stage combiner with its increment memory.
//
// The block takes one grid point per request on the input channel (i_valid,
// o_stall) and returns one updated value per request on the output channel
// (o_valid, i_stall). The APB port holds the substep number (address 0) and the
// step size (address 4); write them only while no request is in flight.
//
// Each request computes step_size*rhs, rounds it and writes it into the
// increment memory under the current substep. It then reads back the stored
// increments of substeps 0 to the current one, one read per cycle from the
// single memory port, and accumulates them with their weights in twelfths.
// A divide-by-three unit, seven bits per cycle, forms the rounded quotient.
//
// After acceptance a request passes through the states load, write, read (one
// per stored increment), drain, clamp, divide and out before o_valid rises.
// One request is in work at a time; the next is accepted once the result has
// been moved into the output register.
//
// Reset clears the control state and the output valid and sets the step size
// to 1.0 and the substep to 0. The increment memory is not cleared. While the
// receiver stalls, the result stays in the output register; a further request
// may still be accepted and worked on, and it waits for the register to free.
`default_nettype none

module multirate_rk_stage_combine import mrkc_pkg::*; (
    input  wire logic                     i_clk,
    input  wire logic                     i_rst_n,
    // Input channel.
    input  wire logic                     i_valid,
    output logic                          o_stall,
    input  wire logic [VAR_IN_W-1:0]      i_var_index,
    input  wire logic [PT_IN_W-1:0]       i_point_index,
    input  wire logic                     i_is_slow,
    input  wire logic signed [DATA_W-1:0] i_rhs,
    input  wire logic signed [DATA_W-1:0] i_old_value,
    // Output channel.
    output logic                          o_valid,
    input  wire logic                     i_stall,
    output logic [PT_IN_W-1:0]            o_point_out,
    output logic signed [DATA_W-1:0]      o_new_value,
    // Configuration port.
    input  wire logic                     psel,
    input  wire logic                     penable,
    input  wire logic                     pwrite,
    input  wire logic [2:0]               paddr,
    input  wire logic [31:0]              pwdata,
    output logic [31:0]                   prdata,
    output logic                          pready
);

    localparam logic signed [ACC_W-1:0] Y_MAX = ACC_W'(64'd12 * (64'd1 << 32) - 64'd1);

    t_state                      r_state, n_state;
    logic [STAGE_W-1:0]          r_stage;
    logic signed [DATA_W-1:0]    r_step;

    logic [STAGE_W-1:0]          r_s, n_s;
    logic [STAGE_W-1:0]          r_k, n_k;
    logic                        r_slow, n_slow;
    logic [ROW_W-1:0]            r_row, n_row;
    logic [PT_W-1:0]             r_pt, n_pt;
    logic [PT_IN_W-1:0]          r_point, n_point;
    logic signed [DATA_W-1:0]    r_rhs, n_rhs;
    logic signed [DATA_W-1:0]    r_old, n_old;
    logic signed [63:0]          r_prod, n_prod;
    logic signed [ACC_W-1:0]     r_acc, n_acc;
    t_weight                     r_rd_w, n_rd_w;
    logic [Z_W-1:0]              r_z, n_z;
    logic [Z_W-1:0]              r_q, n_q;
    logic [1:0]                  r_rem, n_rem;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_out_valid, n_out_valid;
    logic [PT_IN_W-1:0]          r_out_point, n_out_point;
    logic signed [DATA_W-1:0]    r_out_value, n_out_value;

    // Increment memory, one port, registered read data.
    logic signed [DATA_W-1:0]    r_mem [MEM_DEPTH];
    logic signed [DATA_W-1:0]    r_rdata;
    logic                        mem_we;
    logic [ADDR_W-1:0]           mem_addr;
    logic signed [DATA_W-1:0]    mem_wdata;

    logic                        in_accept;
    logic                        out_free;
    logic                        cfg_write;
    logic signed [63:0]          rnd;
    logic signed [63:0]          rnd_sh;
    logic signed [WPROD_W-1:0]   wprod;
    logic signed [ACC_W-1:0]     clamped;
    logic [DATA_W-1:0]           old_bias;

    assign in_accept = i_valid && !o_stall;
    assign out_free  = !r_out_valid || !i_stall;
    assign cfg_write = psel && penable && pwrite && pready;

    assign o_stall     = !i_rst_n || (r_state != ST_IDLE);
    assign o_valid     = r_out_valid;
    assign o_point_out = r_out_point;
    assign o_new_value = r_out_value;
    assign pready      = 1'b1;

    always_comb begin
        prdata = 32'd0;
        case (paddr[2])
            REG_STAGE[0]: prdata = 32'(r_stage);
            REG_STEP[0]:  prdata = r_step;
            default:      prdata = 32'd0;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_stage <= '0;
            r_step  <= 32'sd65536;
        end else if (cfg_write) begin
            case (paddr[2])
                REG_STAGE[0]: r_stage <= pwdata[STAGE_W-1:0];
                REG_STEP[0]:  r_step  <= pwdata;
                default:      r_stage <= r_stage;
            endcase
        end
    end

    // Rounded increment: floor((prod + 2^15) / 2^16), saturated to 32 bits.
    assign rnd    = r_prod + 64'sd32768;
    assign rnd_sh = rnd >>> 16;
    always_comb begin
        if (rnd_sh > 64'sd2147483647) begin
            mem_wdata = 32'sh7FFFFFFF;
        end else if (rnd_sh < -64'sd2147483648) begin
            mem_wdata = 32'sh80000000;
        end else begin
            mem_wdata = rnd_sh[DATA_W-1:0];
        end
    end

    assign wprod    = r_rd_w * r_rdata;
    assign old_bias = {~r_old[DATA_W-1], r_old[DATA_W-2:0]};

    // The biased sum must land in 0 .. 12*2^32-1 for a 32-bit quotient.
    always_comb begin
        if (r_acc < 0) begin
            clamped = '0;
        end else if (r_acc > Y_MAX) begin
            clamped = Y_MAX;
        end else begin
            clamped = r_acc;
        end
    end

    always_comb begin
        logic [1:0] rem;
        logic [2:0] t;
        logic [DIV_BITS-1:0] qb;

        n_state     = r_state;
        n_s         = r_s;
        n_k         = r_k;
        n_slow      = r_slow;
        n_row       = r_row;
        n_pt        = r_pt;
        n_point     = r_point;
        n_rhs       = r_rhs;
        n_old       = r_old;
        n_prod      = r_prod;
        n_acc       = r_acc;
        n_rd_w      = '0;
        n_z         = r_z;
        n_q         = r_q;
        n_rem       = r_rem;
        n_cnt       = r_cnt;
        n_out_valid = r_out_valid && i_stall;
        n_out_point = r_out_point;
        n_out_value = r_out_value;
        mem_we      = 1'b0;
        mem_addr    = ADDR_W'((int'(r_row) + int'(r_k)) * NUM_POINTS + int'(r_pt));

        // The weighted increment of the read issued last cycle.
        if (r_rd_w != 0) begin
            n_acc = r_acc + {{(ACC_W-WPROD_W){wprod[WPROD_W-1]}}, wprod};
        end

        rem = r_rem;
        qb  = '0;
        for (int i = 0; i < DIV_BITS; i++) begin
            t = {rem, r_z[Z_W-1-i]};
            if (t >= 3'd3) begin
                qb[DIV_BITS-1-i] = 1'b1;
                t = t - 3'd3;
            end
            rem = t[1:0];
        end

        case (r_state)
            ST_IDLE: begin
                if (in_accept) begin
                    n_s     = (r_stage > STAGE_W'(FINAL_STG)) ? STAGE_W'(FINAL_STG) : r_stage;
                    n_slow  = i_is_slow;
                    n_row   = ROW_W'((int'(i_is_slow) * NUM_VARS
                                      + int'(mod_vars(i_var_index))) * NUM_STAGES);
                    n_pt    = mod_points(i_point_index);
                    n_point = i_point_index;
                    n_rhs   = i_rhs;
                    n_old   = i_old_value;
                    n_state = ST_LOAD;
                end
            end
            ST_LOAD: begin
                n_prod  = r_step * r_rhs;
                n_acc   = ACC_W'({old_bias, 3'b000}) + ACC_W'({old_bias, 2'b00})
                        + ACC_W'(6);
                n_k     = r_s;
                n_state = ST_WRITE;
            end
            ST_WRITE: begin
                mem_we  = 1'b1;
                n_k     = '0;
                n_state = ST_READ;
            end
            ST_READ: begin
                n_rd_w = weight(r_slow, r_s, r_k);
                if (r_k == r_s) begin
                    n_state = ST_DRAIN;
                end else begin
                    n_k = r_k + 1'b1;
                end
            end
            ST_DRAIN: begin
                n_state = ST_CLAMP;
            end
            ST_CLAMP: begin
                n_z     = Z_W'(clamped[ACC_W-1:2]);
                n_q     = '0;
                n_rem   = '0;
                n_cnt   = '0;
                n_state = ST_DIV;
            end
            ST_DIV: begin
                n_z   = r_z << DIV_BITS;
                n_q   = {r_q[Z_W-DIV_BITS-1:0], qb};
                n_rem = rem;
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    n_state = ST_OUT;
                end else begin
                    n_cnt = r_cnt + 1'b1;
                end
            end
            ST_OUT: begin
                if (out_free) begin
                    n_out_valid = 1'b1;
                    n_out_point = r_point;
                    n_out_value = {~r_q[DATA_W-1], r_q[DATA_W-2:0]};
                    n_state     = ST_IDLE;
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_IDLE;
            r_out_valid <= 1'b0;
            r_rd_w      <= '0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
            r_rd_w      <= n_rd_w;
        end
    end

    always_ff @(posedge i_clk) begin
        r_s         <= n_s;
        r_k         <= n_k;
        r_slow      <= n_slow;
        r_row       <= n_row;
        r_pt        <= n_pt;
        r_point     <= n_point;
        r_rhs       <= n_rhs;
        r_old       <= n_old;
        r_prod      <= n_prod;
        r_acc       <= n_acc;
        r_z         <= n_z;
        r_q         <= n_q;
        r_rem       <= n_rem;
        r_cnt       <= n_cnt;
        r_out_point <= n_out_point;
        r_out_value <= n_out_value;
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_addr] <= mem_wdata;
        end
        r_rdata <= r_mem[mem_addr];
    end

endmodule

`default_nettype wire

// ===== hdl/mrkc_checker.sv =====
// Port-level assertion checker for the stage combiner and its bind statement.
`default_nettype none

module mrkc_checker import mrkc_pkg::*; (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_valid,
    input wire logic                     o_stall,
    input wire logic                     o_valid,
    input wire logic                     i_stall,
    input wire logic [PT_IN_W-1:0]       o_point_out,
    input wire logic signed [DATA_W-1:0] o_new_value
);

    // A stalled result stays presented.
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_point_out) && $stable(o_new_value))
        else $error("stalled result changed or was dropped");

    // Only one request is worked on at a time.
    a_one_in_work: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("second request accepted while one is in work");

    // After acceptance with no result shown, o_valid stays low while the request is loaded and written.
    a_no_early: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall && !o_valid |=> !o_valid ##1 !o_valid)
        else $error("result appeared too early");

    // Reset leaves no result on the output.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_valid)
        else $error("result valid after reset");

endmodule

bind multirate_rk_stage_combine mrkc_checker u_mrkc_checker (.*);

`default_nettype wire
